[hw/rtl/sfp_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the sensor frame parser
// no dependencies

package sfp_pkg;

  localparam logic [7:0] SyncByte = 8'h5A;
  // checksum seed after both sync bytes
  localparam logic [7:0] SyncSum = 8'(2 * SyncByte);
  localparam int MaxPayloadDefault = 60;

  // type byte bits
  localparam int TypeAccelBit = 0;
  localparam int TypeMagBit = 1;
  localparam int TypeGyroBit = 2;
  localparam int TypeEulerBit = 3;

  typedef struct packed {
    logic [7:0]         frame_type;
    logic [7:0]         payload_length;
    logic               has_gyro;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic               has_euler;
    logic [15:0]        yaw_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
  } sfp_result_t;

endpackage

[hw/rtl/sfp_parse.sv]
`timescale 1ns / 1ps
// frame state machine: sync hunt, header, payload capture, checksum check
// depends on sfp_pkg

module sfp_parse #(
  parameter int MAX_PAYLOAD = sfp_pkg::MaxPayloadDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                beat,
  input  logic [7:0]          rx_byte,
  input  logic                chunk_start,
  output logic                res_valid,
  output sfp_pkg::sfp_result_t res
);
  import sfp_pkg::*;

  localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] words_r [5];
  logic [15:0] words_nxt [5];

  logic [4:0]  g_off, e_off;
  logic [7:0]  g_rel, e_rel;
  logic        in_gyro, in_euler;
  logic [2:0]  slot;
  logic        slot_hit;
  logic        g_ok, e_ok;
  logic [7:0]  idx_inc;

  // group offsets, 6 bytes per group present ahead
  always_comb begin
    g_off = (type_r[TypeAccelBit] ? 5'd6 : 5'd0) + (type_r[TypeMagBit] ? 5'd6 : 5'd0);
    e_off = g_off + (type_r[TypeGyroBit] ? 5'd6 : 5'd0);
    g_rel = idx_r - {3'b0, g_off};
    e_rel = idx_r - {3'b0, e_off};
    in_gyro = type_r[TypeGyroBit] && (idx_r >= {3'b0, g_off})
              && (idx_r < {3'b0, g_off} + 8'd4);
    in_euler = type_r[TypeEulerBit] && (idx_r >= {3'b0, e_off})
               && (idx_r < {3'b0, e_off} + 8'd6);
    slot_hit = in_gyro || in_euler;
    if (in_gyro) begin
      slot = {2'b0, g_rel[1]};
    end else begin
      slot = 3'd2 + {1'b0, e_rel[2:1]};
    end
    g_ok = type_r[TypeGyroBit] && ({4'b0, g_off} + 9'd4 <= {1'b0, len_r});
    e_ok = type_r[TypeEulerBit] && ({4'b0, e_off} + 9'd6 <= {1'b0, len_r});
    idx_inc = idx_r + 8'd1;
  end

  always_comb begin
    phase_cur = chunk_start ? PH_SYNC1 : phase_r;
    phase_nxt = phase_r;
    type_nxt = type_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    hold_nxt = hold_r;
    for (int k = 0; k < 5; k++) begin
      words_nxt[k] = words_r[k];
    end
    res_valid = 1'b0;
    if (beat) begin
      case (phase_cur)
        PH_SYNC2: begin
          if (rx_byte == SyncByte) begin
            sum_nxt = SyncSum;
            phase_nxt = PH_TYPE;
          end else begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_TYPE: begin
          type_nxt = rx_byte;
          sum_nxt = sum_r + rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt = rx_byte;
          sum_nxt = sum_r + rx_byte;
          idx_nxt = 8'd0;
          if ({1'b0, rx_byte} > MaxLen) begin
            phase_nxt = PH_SYNC1;
          end else if (rx_byte == 8'd0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          sum_nxt = sum_r + rx_byte;
          if (slot_hit) begin
            if (!idx_r[0]) begin
              hold_nxt = rx_byte;
            end else begin
              words_nxt[slot] = {hold_r, rx_byte};
            end
          end
          idx_nxt = idx_inc;
          if (idx_inc >= len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_nxt = PH_SYNC1;
          res_valid = (rx_byte == sum_r);
        end
        default: begin
          // the first sync phase and unused codes hunt for the sync byte
          phase_nxt = (rx_byte == SyncByte) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  always_comb begin
    res.frame_type = type_r;
    res.payload_length = len_r;
    res.has_gyro = g_ok;
    res.gyro_x = g_ok ? words_r[0] : 16'd0;
    res.gyro_y = g_ok ? words_r[1] : 16'd0;
    res.has_euler = e_ok;
    res.yaw_angle = e_ok ? words_r[2] : 16'd0;
    res.roll_angle = e_ok ? words_r[3] : 16'd0;
    res.pitch_angle = e_ok ? words_r[4] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      type_r <= 8'd0;
      len_r <= 8'd0;
      idx_r <= 8'd0;
      sum_r <= 8'd0;
      hold_r <= 8'd0;
      for (int k = 0; k < 5; k++) begin
        words_r[k] <= 16'd0;
      end
    end else begin
      phase_r <= phase_nxt;
      type_r <= type_nxt;
      len_r <= len_nxt;
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
      hold_r <= hold_nxt;
      for (int k = 0; k < 5; k++) begin
        words_r[k] <= words_nxt[k];
      end
    end
  end

endmodule

[hw/rtl/sfp_outbuf.sv]
`timescale 1ns / 1ps
// result register with one skid entry behind it
// depends on sfp_pkg

module sfp_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  sfp_pkg::sfp_result_t res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output sfp_pkg::sfp_result_t out_res,
  output logic                 full
);
  import sfp_pkg::*;

  logic        out_valid_r;
  logic        skid_valid_r;
  sfp_result_t out_r;
  sfp_result_t skid_r;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res = out_r;
  assign full = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // input is stalled while skid holds a beat, so no new result collides
      out_valid_r <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

endmodule

[hw/rtl/sensor_frame_parser.sv]
`timescale 1ns / 1ps
// sensor frame parser top: one received byte per beat, one result per good frame
// the checksum beat's result is registered, into the skid entry if the output stalls
// one byte per cycle when not stalled; the frame state machine updates every beat
// input stalls only when both the result register and its skid entry are full
// synchronous active-low reset returns to the sync hunt and clears captured words
// depends on sfp_pkg, sfp_parse, sfp_outbuf

module sensor_frame_parser #(
  parameter int MAX_PAYLOAD = sfp_pkg::MaxPayloadDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_chunk_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_type,
  output logic [7:0]         out_payload_length,
  output logic               out_has_gyro,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic               out_has_euler,
  output logic [15:0]        out_yaw_angle,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle
);
  import sfp_pkg::*;

  logic        beat;
  logic        res_valid;
  logic        buf_full;
  sfp_result_t res;
  sfp_result_t out_res;

  assign in_stall = buf_full;
  assign beat = in_valid && !buf_full;

  sfp_parse #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parse (
    .clk(clk),
    .rst_n(rst_n),
    .beat(beat),
    .rx_byte(in_rx_byte),
    .chunk_start(in_chunk_start),
    .res_valid(res_valid),
    .res(res)
  );

  sfp_outbuf u_outbuf (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(res_valid),
    .res(res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_res(out_res),
    .full(buf_full)
  );

  assign out_frame_type = out_res.frame_type;
  assign out_payload_length = out_res.payload_length;
  assign out_has_gyro = out_res.has_gyro;
  assign out_gyro_x = out_res.gyro_x;
  assign out_gyro_y = out_res.gyro_y;
  assign out_has_euler = out_res.has_euler;
  assign out_yaw_angle = out_res.yaw_angle;
  assign out_roll_angle = out_res.roll_angle;
  assign out_pitch_angle = out_res.pitch_angle;

endmodule
